// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VRBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VRBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VRBS_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define VRBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/vrbs_pkg.sv
package vrbs_pkg;

  localparam int STACK_BYTES = 1024;
  localparam int MAX_READ    = 64;
  localparam int ADDR_W      = $clog2(STACK_BYTES);
  localparam int OFS_W       = ADDR_W + 1;
  localparam int LEN_W       = 11;
  localparam int SUM_W       = ((OFS_W > LEN_W) ? OFS_W : LEN_W) + 1;
  localparam int CNT_W       = $clog2(MAX_READ + 1);
  localparam int HDR_BYTES   = 4;
  localparam int HDR_IDX_W   = $clog2(HDR_BYTES);

  typedef enum logic [2:0] {
    MODE_PUSH  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_QUERY = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_RDH0,
    ST_RDH1,
    ST_SETUP,
    ST_STREAM
  } state_t;

  typedef struct packed {
    logic       status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_out;
    logic       is_empty;
    logic       is_full;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/vrbs_store.sv
module vrbs_store import vrbs_pkg::*; (
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [STACK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Hold read data unless a new read is issued.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: rtl/vrbs_ctl.sv
module vrbs_ctl import vrbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic [LEN_W-1:0] length,
  input  logic             last,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_ready,
  output ram_req_t         ram_req,
  input  logic [7:0]       ram_rdata
);

  state_t state, state_next;

  logic [OFS_W-1:0]     top, top_next;
  logic                 rec_open, rec_open_next;
  logic                 rec_rej, rec_rej_next;
  logic [LEN_W-1:0]     wo, wo_next;
  logic [LEN_W-1:0]     pend_len, pend_len_next;
  logic [ADDR_W-1:0]    wptr, wptr_next;
  logic [HDR_IDX_W-1:0] hdr_idx, hdr_idx_next;
  logic [OFS_W-1:0]     base, base_next;
  logic [LEN_W-1:0]     rd_len, rd_len_next;
  logic                 is_pop, is_pop_next;
  logic [7:0]           h_lo, h_lo_next;
  logic [LEN_W-1:0]     h, h_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [CNT_W-1:0]     idx, idx_next;
  logic [ADDR_W-1:0]    rptr, rptr_next;

  logic                 accept;
  logic                 empty_now;
  logic [SUM_W-1:0]     top_ext;
  logic [SUM_W-1:0]     len_ext;
  logic                 no_room;
  logic [LEN_W-1:0]     pe;
  logic                 rej_eff;
  logic [LEN_W-1:0]     wo_eff;
  logic                 do_write;
  logic [SUM_W-1:0]     first_sum;
  logic [ADDR_W-1:0]    wr_addr;
  logic [SUM_W-1:0]     hb_sum;
  logic [SUM_W-1:0]     adv_sum;
  logic [OFS_W-1:0]     pop_top;
  logic [LEN_W-1:0]     min_hl;
  logic [CNT_W-1:0]     cnt_calc;
  logic                 stream_last;
  logic [15:0]          hdr_word;
  logic [15:0]          h_word;

  assign accept    = in_valid && (state == ST_IDLE) && res_ready;
  assign in_stall  = !((state == ST_IDLE) && res_ready);
  assign empty_now = (top == OFS_W'(STACK_BYTES));

  assign top_ext   = SUM_W'(top);
  assign len_ext   = SUM_W'(length);
  assign no_room   = top_ext < (len_ext + SUM_W'(HDR_BYTES));
  assign pe        = rec_open ? pend_len : length;
  assign rej_eff   = rec_open ? rec_rej : no_room;
  assign wo_eff    = rec_open ? wo : '0;
  assign do_write  = !rej_eff && (wo_eff < pe);
  assign first_sum = top_ext - len_ext;
  assign wr_addr   = rec_open ? wptr : first_sum[ADDR_W-1:0];
  assign hb_sum    = top_ext - SUM_W'(pe) - SUM_W'(HDR_BYTES);

  // Pop frees the header and the whole record, capped at the store top.
  assign adv_sum   = SUM_W'(base) + SUM_W'(HDR_BYTES) + SUM_W'(h);
  assign pop_top   = (adv_sum > SUM_W'(STACK_BYTES)) ? OFS_W'(STACK_BYTES)
                                                     : adv_sum[OFS_W-1:0];
  assign min_hl    = (h < rd_len) ? h : rd_len;
  assign cnt_calc  = (min_hl > LEN_W'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                 : min_hl[CNT_W-1:0];
  assign stream_last = ((idx + CNT_W'(1)) == cnt);
  assign hdr_word  = 16'(pend_len);
  assign h_word    = {ram_rdata, h_lo};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_PUSH) begin
            if (last && !rej_eff) state_next = ST_HDR;
          end else if ((mode == MODE_POP) || (mode == MODE_PEEK)) begin
            if (!empty_now) state_next = ST_RDH0;
          end
        end
      end
      ST_HDR: begin
        if (hdr_idx == HDR_IDX_W'(HDR_BYTES - 1)) state_next = ST_IDLE;
      end
      ST_RDH0:  state_next = ST_RDH1;
      ST_RDH1:  state_next = ST_SETUP;
      ST_SETUP: begin
        if (cnt_calc != '0) state_next = ST_STREAM;
        else if (res_ready) state_next = ST_IDLE;
      end
      ST_STREAM: begin
        if (res_ready && stream_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Register next values
  always_comb begin
    top_next      = top;
    rec_open_next = rec_open;
    rec_rej_next  = rec_rej;
    wo_next       = wo;
    pend_len_next = pend_len;
    wptr_next     = wptr;
    hdr_idx_next  = hdr_idx;
    base_next     = base;
    rd_len_next   = rd_len;
    is_pop_next   = is_pop;
    h_lo_next     = h_lo;
    h_next        = h;
    cnt_next      = cnt;
    idx_next      = idx;
    rptr_next     = rptr;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_PUSH) begin
            rec_open_next = 1'b1;
            pend_len_next = pe;
            rec_rej_next  = rej_eff;
            wo_next       = do_write ? (wo_eff + LEN_W'(1)) : wo_eff;
            wptr_next     = do_write ? (wr_addr + ADDR_W'(1)) : wr_addr;
            if (last) begin
              rec_open_next = 1'b0;
              rec_rej_next  = 1'b0;
              wo_next       = '0;
              hdr_idx_next  = '0;
              if (!rej_eff) top_next = hb_sum[OFS_W-1:0];
            end
          end else begin
            // Any other mode drops an open record.
            rec_open_next = 1'b0;
            rec_rej_next  = 1'b0;
            wo_next       = '0;
            if (mode == MODE_CLEAR) top_next = OFS_W'(STACK_BYTES);
            base_next   = top;
            rd_len_next = length;
            is_pop_next = (mode == MODE_POP);
          end
        end
      end
      ST_HDR:  hdr_idx_next = hdr_idx + HDR_IDX_W'(1);
      ST_RDH0: h_lo_next = ram_rdata;
      ST_RDH1: h_next = h_word[LEN_W-1:0];
      ST_SETUP: begin
        cnt_next  = cnt_calc;
        idx_next  = '0;
        rptr_next = base[ADDR_W-1:0] + ADDR_W'(HDR_BYTES + 1);
        if (is_pop && ((cnt_calc != '0) || res_ready)) top_next = pop_top;
      end
      ST_STREAM: begin
        if (res_ready) begin
          idx_next  = idx + CNT_W'(1);
          rptr_next = rptr + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    res            = '0;
    res.last_out   = 1'b1;
    res.is_empty   = (top_next == OFS_W'(STACK_BYTES));
    res_valid      = 1'b0;
    ram_req        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          unique case (mode) inside
            MODE_PUSH: begin
              res.status    = rej_eff;
              ram_req.we    = do_write;
              ram_req.waddr = wr_addr;
              ram_req.wdata = data_byte;
            end
            MODE_POP, MODE_PEEK: begin
              res_valid     = empty_now;
              res.status    = 1'b1;
              ram_req.re    = !empty_now;
              ram_req.raddr = top[ADDR_W-1:0];
            end
            MODE_QUERY: res.is_full = no_room;
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = top[ADDR_W-1:0] + ADDR_W'(hdr_idx);
        case (hdr_idx)
          HDR_IDX_W'(0): ram_req.wdata = hdr_word[7:0];
          HDR_IDX_W'(1): ram_req.wdata = hdr_word[15:8];
          default:       ram_req.wdata = 8'h00;
        endcase
      end
      ST_RDH0: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = base[ADDR_W-1:0] + ADDR_W'(1);
      end
      ST_RDH1: ;
      ST_SETUP: begin
        // Nothing to stream: one empty beat closes the item.
        res_valid     = (cnt_calc == '0);
        ram_req.re    = (cnt_calc != '0);
        ram_req.raddr = base[ADDR_W-1:0] + ADDR_W'(HDR_BYTES);
      end
      ST_STREAM: begin
        res_valid      = 1'b1;
        res.out_byte   = ram_rdata;
        res.byte_valid = 1'b1;
        res.last_out   = stream_last;
        ram_req.re     = res_ready && !stream_last;
        ram_req.raddr  = rptr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      top      <= OFS_W'(STACK_BYTES);
      rec_open <= 1'b0;
      rec_rej  <= 1'b0;
      wo       <= '0;
    end else begin
      state    <= state_next;
      top      <= top_next;
      rec_open <= rec_open_next;
      rec_rej  <= rec_rej_next;
      wo       <= wo_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_len <= pend_len_next;
    wptr     <= wptr_next;
    hdr_idx  <= hdr_idx_next;
    base     <= base_next;
    rd_len   <= rd_len_next;
    is_pop   <= is_pop_next;
    h_lo     <= h_lo_next;
    h        <= h_next;
    cnt      <= cnt_next;
    idx      <= idx_next;
    rptr     <= rptr_next;
  end

endmodule

// File: rtl/variable_record_byte_stack.sv
// Byte stack of variable-length records, each under a 4-byte length header,
// kept in one single-port-per-direction byte RAM with a registered read
// port. After the last byte of a record that fits, the header goes into the
// byte RAM one byte per cycle. Pop and peek fetch the two header bytes and
// size the transfer (states ST_RDH0, ST_RDH1, ST_SETUP), then stream one byte
// per cycle while the output is not stalled (an empty store or a zero-byte
// transfer answers with a single beat). Push bytes, clear, full query and
// unused modes each answer with a single beat. Input is stalled while a pop,
// peek or header write runs and while the output is held. An output register
// separates the result side; the store needs no clearing pass after reset.
`include "assert_macros.svh"

module variable_record_byte_stack import vrbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic [LEN_W-1:0] length,
  input  logic             last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             status,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last_out,
  output logic             is_empty,
  output logic             is_full
);

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  res_t       res;
  res_t       out_res;
  logic       res_valid;
  logic       res_ready;
  logic       in_accept;
  logic       byte_beat;
  logic       clear_take;
  logic       query_take;
  logic       end_beat;

  assign res_ready = !out_valid || !out_stall;
  assign in_accept = in_valid && !in_stall;

  vrbs_store u_store (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  vrbs_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_byte (data_byte),
    .length    (length),
    .last      (last),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Output register: load a new beat whenever the slot is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign status     = out_res.status;
  assign out_byte   = out_res.out_byte;
  assign byte_valid = out_res.byte_valid;
  assign last_out   = out_res.last_out;
  assign is_empty   = out_res.is_empty;
  assign is_full    = out_res.is_full;

  assign byte_beat  = res_valid && res.byte_valid;
  assign clear_take = in_accept && (mode == MODE_CLEAR);
  assign query_take = in_accept && (mode == MODE_QUERY);
  assign end_beat   = out_valid && last_out;

  `VRBS_ASSERT_NOW(a_accept_room, clk, rst, in_accept, res_ready, "input taken without room")
  `VRBS_ASSERT_NOW(a_byte_ok, clk, rst, byte_beat, !res.status && !res.is_full, "bad byte beat")
  `VRBS_ASSERT_NEXT(a_clear_empty, clk, rst, clear_take, end_beat && is_empty, "clear left data")
  `VRBS_ASSERT_NEXT(a_query_beat, clk, rst, query_take, end_beat && !byte_valid, "no query beat")

endmodule

// File: dv/tb_variable_record_byte_stack.sv
`timescale 1ns / 1ps

module tb_variable_record_byte_stack;
  import vrbs_pkg::*;

  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int FIT_MAX     = STACK_BYTES - HDR_BYTES;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 48;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [2:0] m;
    logic [7:0] d;
    int         len;
    logic       lst;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [2:0]       mode = MODE_PUSH;
  logic [7:0]       data_byte = '0;
  logic [LEN_W-1:0] length = '0;
  logic             last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             status;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic             last_out;
  logic             is_empty;
  logic             is_full;

  // shadow of the stack
  logic [7:0] stk_mem [STACK_BYTES];
  bit         stk_set [STACK_BYTES];
  int         top_ofs = STACK_BYTES;
  bit         rec_open = 1'b0;
  bit         rec_rej = 1'b0;
  int         rec_fill = 0;
  int         rec_len = 0;

  res_t       step_beats[$];
  res_t       owed_beats[$];
  dir_row_t   dir_rows[$];
  int         items_sent = 0;
  int         bad_beats = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  int         hold_ticket = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  variable_record_byte_stack uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void mem_put(int idx, logic [7:0] v);
    if (idx >= 0 && idx < STACK_BYTES) begin
      stk_mem[idx] = v;
      stk_set[idx] = 1'b1;
    end
  endfunction

  function automatic logic [7:0] mem_get(int idx);
    return (idx < STACK_BYTES) ? stk_mem[idx] : 8'h00;
  endfunction

  function automatic int top_hdr();
    return {mem_get(top_ofs + 3), mem_get(top_ofs + 2), mem_get(top_ofs + 1), mem_get(top_ofs)};
  endfunction

  // Compute the beats one item causes and advance the shadow stack.
  function automatic void stack_apply(logic [2:0] m, logic [7:0] d, int len, logic lst);
    res_t r;
    int   hdr;
    int   cnt;
    int   base;
    int   i;
    step_beats.delete();
    r = '0;
    r.last_out = 1'b1;
    if (m != MODE_PUSH && rec_open) begin
      rec_open = 1'b0;
      rec_rej = 1'b0;
      rec_fill = 0;
    end
    case (m) inside
      MODE_PUSH: begin
        if (!rec_open) begin
          rec_open = 1'b1;
          rec_fill = 0;
          rec_len = len;
          rec_rej = top_ofs < len + HDR_BYTES;
        end
        if (!rec_rej && rec_fill < rec_len) begin
          mem_put(top_ofs - rec_len + rec_fill, d);
          rec_fill++;
        end
        r.status = rec_rej;
        if (lst) begin
          if (!rec_rej) begin
            base = top_ofs - rec_len - HDR_BYTES;
            mem_put(base, rec_len[7:0]);
            mem_put(base + 1, rec_len[15:8]);
            mem_put(base + 2, 8'h00);
            mem_put(base + 3, 8'h00);
            top_ofs = base;
          end
          rec_open = 1'b0;
          rec_rej = 1'b0;
          rec_fill = 0;
        end
        step_beats.push_back(r);
      end
      MODE_POP, MODE_PEEK: begin
        if (top_ofs >= STACK_BYTES) begin
          r.status = 1'b1;
          step_beats.push_back(r);
        end else begin
          base = top_ofs;
          hdr = top_hdr();
          cnt = (hdr < len) ? hdr : len;
          if (cnt > MAX_READ) cnt = MAX_READ;
          if (cnt == 0) step_beats.push_back(r);
          for (i = 0; i < cnt; i++) begin
            r.out_byte = mem_get(base + HDR_BYTES + i);
            r.byte_valid = 1'b1;
            r.last_out = (i == cnt - 1);
            step_beats.push_back(r);
          end
          if (m == MODE_POP)
            top_ofs = (HDR_BYTES + hdr > STACK_BYTES - base) ? STACK_BYTES
                                                             : base + HDR_BYTES + hdr;
        end
      end
      MODE_CLEAR: begin
        top_ofs = STACK_BYTES;
        step_beats.push_back(r);
      end
      MODE_QUERY: begin
        r.is_full = top_ofs < len + HDR_BYTES;
        step_beats.push_back(r);
      end
      default: step_beats.push_back(r);
    endcase
    for (i = 0; i < step_beats.size(); i++) begin
      r = step_beats[i];
      r.is_empty = (top_ofs >= STACK_BYTES);
      step_beats[i] = r;
    end
  endfunction

  // Trim a pop/peek capacity so no byte that was never stored gets streamed.
  function automatic int readable_cap(int cap);
    int hdr;
    int cnt;
    int i;
    if (top_ofs >= STACK_BYTES) return cap;
    hdr = top_hdr();
    cnt = (hdr < cap) ? hdr : cap;
    if (cnt > MAX_READ) cnt = MAX_READ;
    for (i = 0; i < cnt; i++)
      if (!stk_set[top_ofs + HDR_BYTES + i]) return i;
    return cap;
  endfunction

  function automatic res_t bare_beat(bit st, bit emp, bit full);
    res_t r;
    r = '0;
    r.status = st;
    r.last_out = 1'b1;
    r.is_empty = emp;
    r.is_full = full;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] m, logic [7:0] d, int len, logic lst,
                                  bit typed, res_t want);
    dir_row_t row;
    row.m = m;
    row.d = d;
    row.len = len;
    row.lst = lst;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  task automatic send_beat(logic [2:0] m, logic [7:0] d, int len, logic lst,
                           bit typed = 1'b0, res_t want = '0);
    int i;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (m == MODE_POP || m == MODE_PEEK) len = readable_cap(len);
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= d;
    length    <= len[LEN_W-1:0];
    last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stack_apply(m, d, len, lst);
    if (typed) owed_beats.push_back(want);
    else for (i = 0; i < step_beats.size(); i++) owed_beats.push_back(step_beats[i]);
    items_sent++;
  endtask

  task automatic random_op();
    int pick;
    int len;
    int nb;
    int k;
    bit cut;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      k = $urandom_range(0, 39);
      if (k < 30) len = $urandom_range(0, 12);
      else if (k < 32) len = $urandom_range(MAX_READ - 4, MAX_READ + 8);
      else if (k < 38) len = $urandom_range(13, 300);
      else if (k < 39) len = $urandom_range(301, FIT_MAX);
      else len = $urandom_range(FIT_MAX + 1, LEN_MAX);
      cut = 1'b0;
      nb = (len > 0) ? len : 1;
      // long declared records are sent short to keep the item count down
      if (len > MAX_READ + 8) nb = $urandom_range(1, 4);
      else begin
        case ($urandom_range(0, 9))
          7: nb = $urandom_range(1, nb);
          8: nb = nb + $urandom_range(1, 3);
          9: begin
            nb = $urandom_range(1, nb);
            cut = 1'b1;
          end
          default: ;
        endcase
      end
      for (k = 0; k < nb; k++)
        send_beat(MODE_PUSH, 8'($urandom), (k == 0) ? len : $urandom_range(0, LEN_MAX),
                  !cut && (k == nb - 1));
    end else if (pick < 78) begin
      k = $urandom_range(0, 9);
      len = (k < 5) ? LEN_MAX : (k < 8) ? $urandom_range(0, 8) : $urandom_range(0, LEN_MAX);
      send_beat((pick < 63) ? MODE_POP : MODE_PEEK, 8'($urandom), len,
                1'($urandom_range(0, 1)));
    end else if (pick < 83) begin
      send_beat(MODE_CLEAR, 8'($urandom), $urandom_range(0, LEN_MAX),
                1'($urandom_range(0, 1)));
    end else if (pick < 91) begin
      // probe right at the fit boundary half the time
      if ($urandom_range(0, 1)) len = top_ofs - HDR_BYTES + $urandom_range(0, 2) - 1;
      else len = $urandom_range(0, LEN_MAX);
      if (len < 0) len = 0;
      send_beat(MODE_QUERY, 8'($urandom), len, 1'($urandom_range(0, 1)));
    end else if (pick < 94) begin
      send_beat(3'($urandom_range(MODE_SPARE5, MODE_SPARE7)), 8'($urandom),
                $urandom_range(0, LEN_MAX), 1'($urandom_range(0, 1)));
    end else begin
      send_beat(3'($urandom), 8'($urandom), $urandom_range(0, LEN_MAX),
                1'($urandom_range(0, 1)));
    end
  endtask

  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {status, out_byte, byte_valid, last_out, is_empty, is_full};
      if (owed_beats.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS)
          $display("%0t: beat with nothing owed: st %0d byte %02h bv %0d lo %0d emp %0d full %0d",
                   $time, got.status, got.out_byte, got.byte_valid, got.last_out,
                   got.is_empty, got.is_full);
      end else begin
        want = owed_beats.pop_front();
        if (got.status !== want.status || got.out_byte !== want.out_byte ||
            got.byte_valid !== want.byte_valid || got.last_out !== want.last_out ||
            got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS) begin
            $display("%0t: mismatch exp st %0d byte %02h bv %0d lo %0d emp %0d full %0d",
                     $time, want.status, want.out_byte, want.byte_valid, want.last_out,
                     want.is_empty, want.is_full);
            $display("%0t:          got st %0d byte %02h bv %0d lo %0d emp %0d full %0d",
                     $time, got.status, got.out_byte, got.byte_valid, got.last_out,
                     got.is_empty, got.is_full);
          end
        end
      end
    end
  end

  initial begin
    int ph;
    int goal;
    int i;

    add_row(MODE_POP,   8'h00, 0,           1'b0, 1'b1, bare_beat(1'b1, 1'b1, 1'b0));
    add_row(MODE_PEEK,  8'h00, LEN_MAX,     1'b0, 1'b1, bare_beat(1'b1, 1'b1, 1'b0));
    add_row(MODE_QUERY, 8'h00, FIT_MAX,     1'b0, 1'b1, bare_beat(1'b0, 1'b1, 1'b0));
    add_row(MODE_QUERY, 8'h00, FIT_MAX + 1, 1'b0, 1'b1, bare_beat(1'b0, 1'b1, 1'b1));
    add_row(MODE_QUERY, 8'h00, LEN_MAX,     1'b0, 1'b1, bare_beat(1'b0, 1'b1, 1'b1));
    // oversized record stays refused up to its last byte
    add_row(MODE_PUSH,  8'hFF, LEN_MAX,     1'b0, 1'b1, bare_beat(1'b1, 1'b1, 1'b0));
    add_row(MODE_PUSH,  8'h00, 0,           1'b1, 1'b1, bare_beat(1'b1, 1'b1, 1'b0));
    add_row(MODE_PUSH,  8'h00, 3,           1'b0, 1'b0, '0);
    add_row(MODE_PUSH,  8'hFF, 3,           1'b0, 1'b0, '0);
    add_row(MODE_PUSH,  8'hA5, 3,           1'b1, 1'b0, '0);
    add_row(MODE_PEEK,  8'h00, LEN_MAX,     1'b0, 1'b0, '0);
    add_row(MODE_PEEK,  8'h00, 0,           1'b0, 1'b0, '0);
    add_row(MODE_SPARE5, 8'h00, 0,          1'b0, 1'b1, bare_beat(1'b0, 1'b0, 1'b0));
    // open record dropped by a query
    add_row(MODE_PUSH,  8'h5A, 5,           1'b0, 1'b0, '0);
    add_row(MODE_QUERY, 8'h00, 0,           1'b0, 1'b1, bare_beat(1'b0, 1'b0, 1'b0));
    // extra bytes past the declared length
    add_row(MODE_PUSH,  8'h11, 1,           1'b0, 1'b0, '0);
    add_row(MODE_PUSH,  8'h22, 1,           1'b1, 1'b0, '0);
    add_row(MODE_PUSH,  8'h33, 0,           1'b1, 1'b0, '0);
    add_row(MODE_POP,   8'h00, MAX_READ,    1'b0, 1'b0, '0);
    add_row(MODE_POP,   8'h00, 1,           1'b0, 1'b0, '0);
    add_row(MODE_CLEAR, 8'h00, 0,           1'b0, 1'b1, bare_beat(1'b0, 1'b1, 1'b0));
    // short record that fills the store exactly
    add_row(MODE_PUSH,  8'h77, FIT_MAX,     1'b1, 1'b0, '0);
    add_row(MODE_QUERY, 8'h00, 0,           1'b0, 1'b1, bare_beat(1'b0, 1'b0, 1'b1));
    add_row(MODE_PUSH,  8'h00, 0,           1'b1, 1'b1, bare_beat(1'b1, 1'b0, 1'b0));
    add_row(MODE_POP,   8'h00, LEN_MAX,     1'b0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < dir_rows.size(); i++)
      send_beat(dir_rows[i].m, dir_rows[i].d, dir_rows[i].len, dir_rows[i].lst,
                dir_rows[i].typed, dir_rows[i].want);

    goal = items_sent;
    for (ph = 0; ph < 4; ph++) begin
      // drain before each phase so the sender sits idle with nothing owed
      while (owed_beats.size() != 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      case (ph)
        1: begin
          snd_idle_pct = 64;
          rcv_stall_pct <= 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct <= 64;
        end
        3: begin
          snd_idle_pct = 12;
          rcv_stall_pct <= 12;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_stall_pct <= 0;
          // hold the receiver off while items keep coming
          hold_ticket <= hold_ticket + 1;
        end
      endcase
      goal += PHASE_ITEMS;
      while (items_sent < goal) random_op();
    end

    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
